/* src/cdg3_pkg.sv */
package cdg3_pkg;

  localparam int unsigned DiffBits = 17;
  localparam int unsigned MagBits  = 17;
  localparam int unsigned SumBits  = 34;

  typedef logic signed [DiffBits-1:0] diff_t;
  typedef logic [MagBits-1:0]         mag_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegSizeX = 2'd0;
  localparam logic [1:0] RegSizeY = 2'd1;
  localparam logic [1:0] RegSizeZ = 2'd2;

  // One gradient job handed from the stencil sequencer to the root unit.
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  done;
  } grad_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRd0   = 7'b0000010,
    StRd1   = 7'b0000100,
    StRd2   = 7'b0001000,
    StRd3   = 7'b0010000,
    StWrite = 7'b0100000,
    StPush  = 7'b1000000
  } seq_state_e;

endpackage

/* src/cdg3_ram.sv */
module cdg3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/cdg3_mag.sv */
// Sums the three squares in turn, then a bit-pair-per-cycle square root.
// Emits result items through a two-entry output queue with running extremes.
module cdg3_mag (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            job_valid_i,
  input  cdg3_pkg::grad_t job_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cdg3_pkg::diff_t out_dx_o,
  output cdg3_pkg::diff_t out_dy_o,
  output cdg3_pkg::diff_t out_dz_o,
  output cdg3_pkg::mag_t  out_mag_o,
  output cdg3_pkg::mag_t  out_min_o,
  output cdg3_pkg::mag_t  out_max_o,
  output logic            out_done_o
);

  localparam int unsigned SB = cdg3_pkg::SumBits;
  localparam int unsigned RB = cdg3_pkg::MagBits + 1;
  localparam int unsigned DB = cdg3_pkg::DiffBits;

  typedef struct packed {
    cdg3_pkg::grad_t g;
    cdg3_pkg::mag_t  mag;
    cdg3_pkg::mag_t  mn;
    cdg3_pkg::mag_t  mx;
  } res_t;

  cdg3_pkg::grad_t job_q;
  logic            act_q, act_d;
  logic [1:0]      sq_q, sq_d;
  logic [4:0]      it_q, it_d;
  logic [SB-1:0]   rem_q, rem_d;
  logic [RB-1:0]   root_q, root_d;
  logic [SB-1:0]   sum_q, sum_d;
  logic [SB-1:0]   prod;
  cdg3_pkg::diff_t opnd;
  logic [DB-1:0]   aop;
  cdg3_pkg::mag_t  min_q, max_q;
  res_t            fifo_q [2];
  logic [1:0]      cnt_q;
  logic            rd_q;
  logic            push, pop;
  res_t            nr;
  logic [SB+1:0]   trial;
  logic [SB+1:0]   remsh;
  cdg3_pkg::mag_t  nmag;

  always_comb begin
    case (sq_q)
      2'd0:    opnd = job_q.dx;
      2'd1:    opnd = job_q.dy;
      default: opnd = job_q.dz;
    endcase
  end
  // Square the magnitude: a 17 by 17 bit product.
  assign aop  = opnd[DB-1] ? -opnd : opnd;
  assign prod = SB'(aop) * SB'(aop);

  // Restoring root: bring in two bits of the sum each cycle.
  assign remsh = {rem_q, sum_q[SB-1 -: 2]};
  assign trial = {(SB+2-RB-2)'(0), root_q, 2'b01};

  always_comb begin
    act_d  = act_q;
    sq_d   = sq_q;
    it_d   = it_q;
    rem_d  = rem_q;
    root_d = root_q;
    sum_d  = sum_q;
    push   = 1'b0;
    if (job_valid_i) begin
      act_d = 1'b1;
      sq_d  = 2'd0;
      it_d  = '0;
      sum_d = '0;
      rem_d = '0;
      root_d = '0;
    end else if (act_q) begin
      if (sq_q != 2'd3) begin
        sum_d = sum_q + prod;
        sq_d  = sq_q + 2'd1;
      end else begin
        sum_d = {sum_q[SB-3:0], 2'b00};
        if (remsh >= trial) begin
          rem_d  = SB'(remsh - trial);
          root_d = {root_q[RB-2:0], 1'b1};
        end else begin
          rem_d  = SB'(remsh);
          root_d = {root_q[RB-2:0], 1'b0};
        end
        it_d = it_q + 5'd1;
        if (it_q == 5'(SB/2 - 1)) begin
          act_d = 1'b0;
          push  = 1'b1;
        end
      end
    end
  end

  assign nmag = cdg3_pkg::MagBits'(root_d);
  always_comb begin
    nr.g   = job_q;
    nr.mag = nmag;
    nr.mn  = (nmag < min_q) ? nmag : min_q;
    nr.mx  = (nmag > max_q) ? nmag : max_q;
  end

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      sq_q  <= '0;
      it_q  <= '0;
      cnt_q <= '0;
      rd_q  <= 1'b0;
      min_q <= '1;
      max_q <= '0;
    end else begin
      act_q <= act_d;
      sq_q  <= sq_d;
      it_q  <= it_d;
      if (clr_i) begin
        min_q <= '1;
        max_q <= '0;
      end else if (push) begin
        if (job_q.done) begin
          min_q <= '1;
          max_q <= '0;
        end else begin
          min_q <= nr.mn;
          max_q <= nr.mx;
        end
      end
      if (push) begin
        fifo_q[rd_q ^ (cnt_q == 2'd1)] <= nr;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    sum_q  <= sum_d;
    if (job_valid_i) begin
      job_q <= job_i;
    end
  end

  assign busy_o     = act_q || cnt_q == 2'd2 || (cnt_q == 2'd1 && !pop);
  assign out_dx_o   = fifo_q[rd_q].g.dx;
  assign out_dy_o   = fifo_q[rd_q].g.dy;
  assign out_dz_o   = fifo_q[rd_q].g.dz;
  assign out_mag_o  = fifo_q[rd_q].mag;
  assign out_min_o  = fifo_q[rd_q].mn;
  assign out_max_o  = fifo_q[rd_q].mx;
  assign out_done_o = fifo_q[rd_q].g.done;

endmodule

/* src/central_difference_gradient_3d.sv */
// Streaming 3-D central-difference gradient.
// Input channel: sample_i with in_valid_i / in_stall_o, one voxel per item in
// raster order (x fastest, then y, then z). Output channel: out_valid_o /
// out_stall_i with diff_x/y/z_o (unhalved differences), magnitude_o (floor
// square root of the summed squares), running min/max magnitude and
// volume_done_o on the last result of the volume.
// A sample of plane 0 gives its own border result; plane 1 gives nothing;
// later planes give the result for the plane before; the last plane also
// gives its own border result after that one.
// Two planes live in one single-port-read RAM of 2*MAX_SIZE_X*MAX_SIZE_Y
// words. Each item takes a back read and four neighbor reads (one per cycle),
// one write and a push. The magnitude unit then sums the three squares and
// takes the square root bit pair by bit pair. Input stays stalled until the
// unit is idle and its result is taken, so a new sample waits until the
// results of the one before it are taken; a last-plane item gives its border
// result after its main result.
// Reset (asynchronous, active low) sets sizes to 128, position to the
// volume start and the extremes to their reset values; no RAM clearing.
// A size register write restarts the volume. While the receiver stalls a
// waiting result, in_stall_o stays high.
module central_difference_gradient_3d #(
  parameter int unsigned MAX_SIZE_X  = 128,
  parameter int unsigned MAX_SIZE_Y  = 128,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] diff_x_o,
  output logic [16:0] diff_y_o,
  output logic [16:0] diff_z_o,
  output logic [16:0] magnitude_o,
  output logic [16:0] min_magnitude_o,
  output logic [16:0] max_magnitude_o,
  output logic        volume_done_o
);

  localparam int unsigned PW    = MAX_SIZE_X * MAX_SIZE_Y;
  localparam int unsigned Depth = 2 * PW;
  localparam int unsigned AB    = $clog2(Depth);

  logic [7:0]  size_x_q, size_y_q;
  logic [12:0] size_z_q;
  logic [10:0] sx, sy; // clamped sizes
  logic [12:0] sz;
  logic [10:0] px_q, py_q;
  logic [11:0] pz_q;
  logic [10:0] x, y;
  logic [11:0] z;
  logic        wrap;

  cdg3_pkg::seq_state_e st_q, st_d;
  logic [15:0] s_q;
  logic [16:0] nb_q [5];
  logic        inner;
  logic [AB-1:0] raddr, waddr;
  logic [15:0] rdata;
  logic        we;
  logic        job_valid;
  cdg3_pkg::grad_t job;
  logic        busy;
  logic        pend_q;
  logic        main_q;
  logic        accept;
  logic        clr;
  logic        last_plane;
  logic [15:0] smask;

  always_comb begin
    sx = (size_x_q < 8'd3) ? 11'd3 :
         ({3'd0, size_x_q} > 11'(MAX_SIZE_X)) ? 11'(MAX_SIZE_X) : {3'd0, size_x_q};
    sy = (size_y_q < 8'd3) ? 11'd3 :
         ({3'd0, size_y_q} > 11'(MAX_SIZE_Y)) ? 11'(MAX_SIZE_Y) : {3'd0, size_y_q};
    sz = (size_z_q < 13'd3) ? 13'd3 : (size_z_q > 13'd4096) ? 13'd4096 : size_z_q;
  end

  // Out-of-range position (after a size change) restarts at the origin.
  assign wrap = px_q >= sx || py_q >= sy || {1'b0, pz_q} >= sz;
  assign x = wrap ? '0 : px_q;
  assign y = wrap ? '0 : py_q;
  assign z = wrap ? '0 : pz_q;

  assign smask = 16'((17'd1 << SAMPLE_BITS) - 17'd1);
  assign clr   = cfg_we_i && (cfg_index_i == cdg3_pkg::RegSizeX ||
                              cfg_index_i == cdg3_pkg::RegSizeY ||
                              cfg_index_i == cdg3_pkg::RegSizeZ);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = st_q != cdg3_pkg::StIdle || busy;
  assign inner = x != 0 && x != sx - 11'd1 && y != 0 && y != sy - 11'd1;
  assign last_plane = {1'b0, z} == sz - 13'd1;

  function automatic logic [AB-1:0] addr(input logic slot, input logic [10:0] ax,
                                         input logic [10:0] ay);
    logic [AB:0] a;
    a = {AB{1'b0}} + (slot ? (AB+1)'(PW) : '0) + (AB+1)'(ay) * (AB+1)'(MAX_SIZE_X)
        + (AB+1)'(ax);
    return (a < (AB+1)'(Depth)) ? a[AB-1:0] : '0;
  endfunction

  always_comb begin
    case (st_q)
      cdg3_pkg::StRd0: raddr = addr(~z[0], x + 11'd1, y);
      cdg3_pkg::StRd1: raddr = addr(~z[0], x - 11'd1, y);
      cdg3_pkg::StRd2: raddr = addr(~z[0], x, y + 11'd1);
      cdg3_pkg::StRd3: raddr = addr(~z[0], x, y - 11'd1);
      default:         raddr = addr(z[0], x, y);
    endcase
  end
  assign waddr = addr(z[0], x, y);
  assign we    = st_q == cdg3_pkg::StWrite;

  cdg3_ram #(.Width(16), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: Idle issues the back read, Rd0..Rd3 issue the neighbors
  // while collecting the previous read, Write stores the sample and
  // collects the last neighbor, Push hands the jobs to the magnitude unit.
  always_comb begin
    st_d = st_q;
    case (st_q)
      cdg3_pkg::StIdle:  if (accept) st_d = cdg3_pkg::StRd0;
      cdg3_pkg::StRd0:   st_d = cdg3_pkg::StRd1;
      cdg3_pkg::StRd1:   st_d = cdg3_pkg::StRd2;
      cdg3_pkg::StRd2:   st_d = cdg3_pkg::StRd3;
      cdg3_pkg::StRd3:   st_d = cdg3_pkg::StWrite;
      cdg3_pkg::StWrite: st_d = cdg3_pkg::StPush;
      cdg3_pkg::StPush:  if (!busy && !(main_q && pend_q)) st_d = cdg3_pkg::StIdle;
      default:           st_d = cdg3_pkg::StIdle;
    endcase
  end

  // Job selection in Push: first the stencil / plane-0 result, then the
  // last-plane border result.
  always_comb begin
    job_valid = 1'b0;
    job = '0;
    if (st_q == cdg3_pkg::StPush && !busy) begin
      if (main_q) begin
        job_valid = 1'b1;
        if (z >= 12'd2 && inner) begin
          job.dx = 17'({1'b0, nb_q[1][15:0]}) - 17'({1'b0, nb_q[2][15:0]});
          job.dy = 17'({1'b0, nb_q[3][15:0]}) - 17'({1'b0, nb_q[4][15:0]});
          job.dz = 17'({1'b0, s_q}) - 17'({1'b0, nb_q[0][15:0]});
        end
      end else if (pend_q) begin
        job_valid = 1'b1;
        job.done  = x == sx - 11'd1 && y == sy - 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= cdg3_pkg::StIdle;
      size_x_q <= 8'd128;
      size_y_q <= 8'd128;
      size_z_q <= 13'd128;
      px_q     <= '0;
      py_q     <= '0;
      pz_q     <= '0;
      pend_q   <= 1'b0;
      main_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (clr) begin
        px_q <= '0;
        py_q <= '0;
        pz_q <= '0;
        case (cfg_index_i)
          cdg3_pkg::RegSizeX: size_x_q <= cfg_data_i[7:0];
          cdg3_pkg::RegSizeY: size_y_q <= cfg_data_i[7:0];
          cdg3_pkg::RegSizeZ: size_z_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == cdg3_pkg::StWrite) begin
        main_q <= z != 12'd1;
        pend_q <= last_plane;
      end
      if (st_q == cdg3_pkg::StPush && !busy) begin
        if (main_q) begin
          main_q <= 1'b0;
        end else begin
          pend_q <= 1'b0;
        end
      end
      if (st_q == cdg3_pkg::StPush && st_d == cdg3_pkg::StIdle) begin
        if (x == sx - 11'd1) begin
          px_q <= '0;
          if (y == sy - 11'd1) begin
            py_q <= '0;
            pz_q <= last_plane ? '0 : z + 12'd1;
          end else begin
            py_q <= y + 11'd1;
            pz_q <= z;
          end
        end else begin
          px_q <= x + 11'd1;
          py_q <= y;
          pz_q <= z;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= sample_i & smask;
    end
    case (st_q)
      cdg3_pkg::StRd0:   nb_q[0] <= {1'b0, rdata};
      cdg3_pkg::StRd1:   nb_q[1] <= {1'b0, rdata};
      cdg3_pkg::StRd2:   nb_q[2] <= {1'b0, rdata};
      cdg3_pkg::StRd3:   nb_q[3] <= {1'b0, rdata};
      cdg3_pkg::StWrite: nb_q[4] <= {1'b0, rdata};
      default: ;
    endcase
  end

  cdg3_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (clr),
    .job_valid_i (job_valid),
    .job_i       (job),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_dx_o    (diff_x_o),
    .out_dy_o    (diff_y_o),
    .out_dz_o    (diff_z_o),
    .out_mag_o   (magnitude_o),
    .out_min_o   (min_magnitude_o),
    .out_max_o   (max_magnitude_o),
    .out_done_o  (volume_done_o)
  );

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxX = 128;
  localparam int unsigned MaxY = 128;
  localparam int unsigned MaxZ = 4096;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned HoldCycles = 600;   // long receiver hold-off
  localparam int unsigned ItemCount = 1900;
  localparam logic [1:0] RegUnused = 2'd3;    // index beyond the register list

  // One expected gradient result.
  typedef struct {
    cdg3_pkg::diff_t dx;
    cdg3_pkg::diff_t dy;
    cdg3_pkg::diff_t dz;
    cdg3_pkg::mag_t  mag;
    cdg3_pkg::mag_t  mag_min;
    cdg3_pkg::mag_t  mag_max;
    bit    done;
  } grad_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] sample_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [16:0] diff_x_o;
  logic [16:0] diff_y_o;
  logic [16:0] diff_z_o;
  logic [16:0] magnitude_o;
  logic [16:0] min_magnitude_o;
  logic [16:0] max_magnitude_o;
  logic        volume_done_o;

  central_difference_gradient_3d u_dut (.*);

  // Stimulus and expected-results storage.
  logic [15:0] sample_q[$];
  grad_res_t   grad_q[$];

  // Shadow of the block: sizes, position, extremes and both plane slots.
  logic [7:0]  sh_size_x, sh_size_y;
  logic [12:0] sh_size_z;
  int unsigned vox_x, vox_y, vox_z;
  cdg3_pkg::mag_t run_min, run_max;
  logic [15:0] plane_mem [0:2*MaxX*MaxY-1];

  int unsigned tx_idle_pct, rx_stall_pct;
  int unsigned hold_start, hold_cnt;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    return (v < 3) ? 3 : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned mem_addr(int unsigned slot, int unsigned x, int unsigned y);
    return (slot & 1) * MaxX * MaxY + y * MaxX + x;
  endfunction

  // Floor square root, bit by bit.
  function automatic cdg3_pkg::mag_t floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return cdg3_pkg::mag_t'(root);
  endfunction

  function automatic void restart_volume();
    vox_x = 0;
    vox_y = 0;
    vox_z = 0;
    run_min = '1;
    run_max = '0;
  endfunction

  function automatic void push_gradient(int dx, int dy, int dz, bit done);
    grad_res_t r;
    longint unsigned sum;
    sum = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
    r.mag = floor_sqrt(sum);
    if (r.mag < run_min) run_min = r.mag;
    if (r.mag > run_max) run_max = r.mag;
    r.dx = cdg3_pkg::diff_t'(dx);
    r.dy = cdg3_pkg::diff_t'(dy);
    r.dz = cdg3_pkg::diff_t'(dz);
    r.mag_min = run_min;
    r.mag_max = run_max;
    r.done = done;
    grad_q.push_back(r);
  endfunction

  // Works out the results one accepted sample causes.
  function automatic void predict_gradients(logic [15:0] smp);
    int unsigned sx, sy, sz, x, y, z, mid;
    int dx, dy, dz;
    sx = clamp_size(sh_size_x, MaxX);
    sy = clamp_size(sh_size_y, MaxY);
    sz = clamp_size(sh_size_z, MaxZ);
    if (vox_x >= sx || vox_y >= sy || vox_z >= sz) restart_volume();
    x = vox_x;
    y = vox_y;
    z = vox_z;
    if (z == 0) begin
      push_gradient(0, 0, 0, 1'b0);
    end else if (z >= 2) begin
      mid = (z - 1) & 1;
      dx = 0;
      dy = 0;
      dz = 0;
      // interior voxel of the plane before
      if (x != 0 && x != sx - 1 && y != 0 && y != sy - 1) begin
        dx = int'(plane_mem[mem_addr(mid, x + 1, y)]) - int'(plane_mem[mem_addr(mid, x - 1, y)]);
        dy = int'(plane_mem[mem_addr(mid, x, y + 1)]) - int'(plane_mem[mem_addr(mid, x, y - 1)]);
        dz = int'(smp) - int'(plane_mem[mem_addr(z, x, y)]);
      end
      push_gradient(dx, dy, dz, 1'b0);
    end
    plane_mem[mem_addr(z, x, y)] = smp;
    // last plane: own border voxel follows
    if (z == sz - 1) push_gradient(0, 0, 0, (x == sx - 1) && (y == sy - 1));
    x++;
    if (x == sx) begin
      x = 0;
      y++;
      if (y == sy) begin
        y = 0;
        z++;
      end
    end
    if (z >= sz) begin
      restart_volume();
    end else begin
      vox_x = x;
      vox_y = y;
      vox_z = z;
    end
  endfunction

  // Driver: offers queued samples, predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_gradients(sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counter for the receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (hold_start != 0) begin
      hold_cnt <= hold_start;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: random stalls, compares each accepted result with the oldest one expected.
  always @(posedge clk_i or negedge rst_ni) begin
    grad_res_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_cnt > 1) || ($urandom_range(99) < rx_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (grad_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: mag %0d", magnitude_o);
        end else begin
          e = grad_q.pop_front();
          if (diff_x_o !== e.dx || diff_y_o !== e.dy || diff_z_o !== e.dz ||
              magnitude_o !== e.mag || min_magnitude_o !== e.mag_min ||
              max_magnitude_o !== e.mag_max || volume_done_o !== e.done) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp d=%0d/%0d/%0d m=%0d mn=%0d mx=%0d done=%0d",
                       e.dx, e.dy, e.dz, e.mag, e.mag_min, e.mag_max, e.done,
                       " got d=%0d/%0d/%0d m=%0d mn=%0d mx=%0d done=%0d",
                       $signed(diff_x_o), $signed(diff_y_o), $signed(diff_z_o),
                       magnitude_o, min_magnitude_o, max_magnitude_o, volume_done_o);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // shadow follows the block; a valid index restarts the volume
    if (idx == cdg3_pkg::RegSizeX) sh_size_x = val[7:0];
    else if (idx == cdg3_pkg::RegSizeY) sh_size_y = val[7:0];
    else if (idx == cdg3_pkg::RegSizeZ) sh_size_z = val;
    if (idx != RegUnused) restart_volume();
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid_i || grad_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase, total, vol, cnt, sx, sy, sz;
    logic [12:0] vx, vy, vz;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_start = 0;
    sh_size_x = 8'd128;
    sh_size_y = 8'd128;
    sh_size_z = 13'd128;
    restart_volume();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: sizes below range saturate to 3, unused index ignored.
    // Far-side voxels full scale gives the largest gradient and magnitude.
    write_reg(cdg3_pkg::RegSizeX, 13'd0);
    write_reg(cdg3_pkg::RegSizeY, 13'd1);
    write_reg(cdg3_pkg::RegSizeZ, 13'd2);
    write_reg(RegUnused, 13'h1fff);
    for (int z = 0; z < 3; z++)
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++)
          sample_q.push_back((x == 2 || y == 2 || z == 2) ? 16'hffff : 16'h0000);
    wait_idle();

    // Random volumes, mostly complete, some cut short.
    phase = 0;
    total = 27;
    while (total < ItemCount) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      vx = 13'($urandom_range(3, 8));
      vy = 13'($urandom_range(3, 6));
      vz = 13'($urandom_range(3, 6));
      if ($urandom_range(5) == 0) vx = 13'($urandom_range(0, 2));
      if ($urandom_range(5) == 0) vy = 13'($urandom_range(0, 2));
      if ($urandom_range(5) == 0) vz = 13'($urandom_range(0, 2));
      if (phase == 3) begin
        vx = 13'd255;   // widest rows, saturates to the maximum
        vy = 13'd3;
        vz = 13'd3;
      end else if (phase == 6) begin
        vx = 13'd3;     // deepest volume, saturates to the maximum
        vy = 13'd3;
        vz = 13'h1fff;
      end else if (phase == 9) begin
        vx = 13'd128;
        vy = 13'd128;
        vz = 13'd4096;
      end
      // random upper bits are dropped by the 8-bit size registers
      write_reg(cdg3_pkg::RegSizeX, {5'($urandom), vx[7:0]});
      write_reg(cdg3_pkg::RegSizeY, {5'($urandom), vy[7:0]});
      write_reg(cdg3_pkg::RegSizeZ, vz);
      if ($urandom_range(3) == 0) write_reg(RegUnused, 13'($urandom));
      sx = clamp_size(vx[7:0], MaxX);
      sy = clamp_size(vy[7:0], MaxY);
      sz = clamp_size(vz, MaxZ);
      vol = sx * sy * sz;
      cnt = vol;
      if (phase == 3 || phase == 9) cnt = 2 * sx * sy / ((phase == 9) ? 64 : 1) + 20;
      if (phase == 6) cnt = 80;
      if (cnt > vol || $urandom_range(7) == 0) cnt = $urandom_range(1, vol);
      if (phase == 3) cnt = 300;
      if (phase == 9) cnt = 60;
      // several whole volumes back to back now and then
      if (phase % 5 == 4 && vol < 200) cnt = 2 * vol + $urandom_range(0, vol);
      if (cnt > ItemCount - total) cnt = ItemCount - total;
      if (phase == 1) hold_start <= HoldCycles;
      for (int i = 0; i < cnt; i++)
        sample_q.push_back(($urandom_range(3) == 0) ? {16{1'($urandom)}} : 16'($urandom));
      @(posedge clk_i);
      hold_start <= 0;
      total += cnt;
      wait_idle();
      phase++;
    end

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
src/cdg3_pkg.sv
src/cdg3_ram.sv
src/cdg3_mag.sv
src/central_difference_gradient_3d.sv
tb/sv/tb_top.sv
